>>> rtl/core/dominator_frontier_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// dominator_frontier_engine_unit_assert
// Assertion macros shared by the dominator frontier engine.
// ----------------------------------------------------------------------------
`ifndef DOMINATOR_FRONTIER_ENGINE_UNIT_ASSERT_SVH
`define DOMINATOR_FRONTIER_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define DFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Types and constants of the dominator frontier engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

   localparam int unsigned ROW_W      = 32;
   localparam int unsigned ROW_DEPTH  = 32;
   localparam int unsigned IDOM_W     = 6;
   localparam logic [5:0]  NO_IDOM    = 6'd63;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT,
      ST_D_PRED,
      ST_D_LOAD,
      ST_D_SCAN,
      ST_D_AND,
      ST_D_WRITE,
      ST_I_DOM,
      ST_I_LOAD,
      ST_I_SCAN,
      ST_I_TEST,
      ST_F_PRED,
      ST_F_LOAD,
      ST_F_SCAN,
      ST_F_WALK,
      ST_F_MARK,
      ST_E_RD,
      ST_E_OUT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/dfe_ram.sv
// ----------------------------------------------------------------------------
// dfe_ram
// Single write port, single read port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/core/dominator_frontier_engine_unit.sv
// ----------------------------------------------------------------------------
// dominator_frontier_engine_unit
// Iterative dominator sets, immediate dominators and dominance frontiers
// over a stored predecessor table.
// ----------------------------------------------------------------------------
//
//  channel  ports                         handshake
//  req      req_operation/index/mask      start & !busy
//  rsp      rsp_* payload                 rsp_valid, one-cycle strobe per beat
//  csr      csr_write_data                csr_write_enable
//
// A compute beat of n blocks runs, all through RAMs with a registered read:
// init; dominator passes over the blocks, repeated until no set changes;
// idom search; frontier walks up the idom chain; then one result beat per
// block. busy is high over the whole compute.
// Reset clears control and sets the block count to 1; the RAMs are not cleared.
// The receiver cannot stall: each result beat is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dominator_frontier_engine_unit #(
   parameter int unsigned MAX_BLOCKS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [4:0]  req_block_index,
   input  wire logic [31:0] req_pred_mask,
   output logic             rsp_valid,
   output logic [4:0]       rsp_out_block,
   output logic             rsp_has_idom,
   output logic [4:0]       rsp_idom_block,
   output logic [31:0]      rsp_dom_set,
   output logic [31:0]      rsp_frontier_set,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [5:0]  csr_write_data
);

   `include "dominator_frontier_engine_unit_assert.svh"

   localparam int unsigned LIMIT   = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
   localparam logic [5:0]  LIMIT_N = 6'(LIMIT);

   dfe_pkg::state_type state_ff, state_in;

   logic [5:0]  block_count_ff;
   logic [5:0]  n_ff, n_in;
   logic [31:0] all_ff, all_in;
   logic [5:0]  idx_ff, idx_in;
   logic [5:0]  sub_ff, sub_in;
   logic [5:0]  runner_ff, runner_in;
   logic [5:0]  steps_ff, steps_in;
   logic [5:0]  ib_ff, ib_in;
   logic [31:0] preds_ff, preds_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] old_ff, old_in;
   logic [31:0] strict_ff, strict_in;
   logic        changed_ff, changed_in;

   logic        pred_we, dom_we, idom_we, front_we;
   logic [4:0]  pred_wa, dom_wa, idom_wa, front_wa;
   logic [31:0] pred_wd, dom_wd, front_wd;
   logic [5:0]  idom_wd;
   logic [4:0]  pred_ra, dom_ra, idom_ra, front_ra;
   logic [31:0] pred_rd, dom_rd, front_rd;
   logic [5:0]  idom_rd;

   logic [5:0]  eff_n;
   logic [31:0] eff_all;
   logic        last_idx, sub_end, join_blk, walk_stop, idom_hit, dom_diff;
   logic [31:0] imask, smask, nd, pf;

   logic        rsp_valid_ff;
   logic [4:0]  rsp_out_block_ff, rsp_idom_block_ff;
   logic        rsp_has_idom_ff, rsp_last_ff;
   logic [31:0] rsp_dom_set_ff, rsp_frontier_set_ff;
   logic        has_idom;

   dfe_ram #(.WIDTH(dfe_pkg::ROW_W), .DEPTH(dfe_pkg::ROW_DEPTH)) u_pred (
      .clock(clock), .wr_en(pred_we), .wr_addr(pred_wa), .wr_data(pred_wd),
      .rd_addr(pred_ra), .rd_data(pred_rd));

   dfe_ram #(.WIDTH(dfe_pkg::ROW_W), .DEPTH(dfe_pkg::ROW_DEPTH)) u_dom (
      .clock(clock), .wr_en(dom_we), .wr_addr(dom_wa), .wr_data(dom_wd),
      .rd_addr(dom_ra), .rd_data(dom_rd));

   dfe_ram #(.WIDTH(dfe_pkg::IDOM_W), .DEPTH(dfe_pkg::ROW_DEPTH)) u_idom (
      .clock(clock), .wr_en(idom_we), .wr_addr(idom_wa), .wr_data(idom_wd),
      .rd_addr(idom_ra), .rd_data(idom_rd));

   dfe_ram #(.WIDTH(dfe_pkg::ROW_W), .DEPTH(dfe_pkg::ROW_DEPTH)) u_front (
      .clock(clock), .wr_en(front_we), .wr_addr(front_wa), .wr_data(front_wd),
      .rd_addr(front_ra), .rd_data(front_rd));

   // effective block count and mask
   always_comb begin
      if (block_count_ff == 6'd0) begin
         eff_n = 6'd1;
      end else if (block_count_ff > LIMIT_N) begin
         eff_n = LIMIT_N;
      end else begin
         eff_n = block_count_ff;
      end
      eff_all = 32'((33'd1 << eff_n) - 33'd1);
   end

   assign busy      = (state_ff != dfe_pkg::ST_IDLE);
   assign last_idx  = (idx_ff == (n_ff - 6'd1));
   assign sub_end   = (sub_ff == n_ff);
   assign imask     = 32'd1 << idx_ff[4:0];
   assign smask     = 32'd1 << sub_ff[4:0];
   assign nd        = ((preds_ff == 32'd0) ? 32'd0 : acc_ff) | imask;
   assign dom_diff  = (nd != old_ff);
   assign pf        = pred_rd & all_ff;
   assign join_blk  = ((pf & (pf - 32'd1)) != 32'd0);
   assign walk_stop = (runner_ff == ib_ff) || (runner_ff >= n_ff) || (steps_ff == n_ff);
   assign idom_hit  = ((strict_ff & ~smask & ~dom_rd) == 32'd0);
   assign has_idom  = (idom_rd < n_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfe_pkg::ST_IDLE: begin
            if (start && req_operation == dfe_pkg::OP_COMPUTE) state_in = dfe_pkg::ST_INIT;
         end
         dfe_pkg::ST_INIT: begin
            if (last_idx) begin
               state_in = (n_ff == 6'd1) ? dfe_pkg::ST_E_RD : dfe_pkg::ST_D_PRED;
            end
         end
         dfe_pkg::ST_D_PRED: state_in = dfe_pkg::ST_D_LOAD;
         dfe_pkg::ST_D_LOAD: state_in = dfe_pkg::ST_D_SCAN;
         dfe_pkg::ST_D_SCAN: begin
            if (sub_end) begin
               state_in = dfe_pkg::ST_D_WRITE;
            end else if (preds_ff[sub_ff[4:0]]) begin
               state_in = dfe_pkg::ST_D_AND;
            end
         end
         dfe_pkg::ST_D_AND: state_in = dfe_pkg::ST_D_SCAN;
         dfe_pkg::ST_D_WRITE: begin
            if (last_idx && !(changed_ff || dom_diff)) begin
               state_in = dfe_pkg::ST_I_DOM;
            end else begin
               state_in = dfe_pkg::ST_D_PRED;
            end
         end
         dfe_pkg::ST_I_DOM:  state_in = dfe_pkg::ST_I_LOAD;
         dfe_pkg::ST_I_LOAD: state_in = dfe_pkg::ST_I_SCAN;
         dfe_pkg::ST_I_SCAN: begin
            if (sub_end) begin
               state_in = last_idx ? dfe_pkg::ST_F_PRED : dfe_pkg::ST_I_DOM;
            end else if (strict_ff[sub_ff[4:0]]) begin
               state_in = dfe_pkg::ST_I_TEST;
            end
         end
         dfe_pkg::ST_I_TEST: begin
            if (idom_hit) begin
               state_in = last_idx ? dfe_pkg::ST_F_PRED : dfe_pkg::ST_I_DOM;
            end else begin
               state_in = dfe_pkg::ST_I_SCAN;
            end
         end
         dfe_pkg::ST_F_PRED: state_in = dfe_pkg::ST_F_LOAD;
         dfe_pkg::ST_F_LOAD: begin
            if (!join_blk) begin
               state_in = last_idx ? dfe_pkg::ST_E_RD : dfe_pkg::ST_F_PRED;
            end else begin
               state_in = dfe_pkg::ST_F_SCAN;
            end
         end
         dfe_pkg::ST_F_SCAN: begin
            if (sub_end) begin
               state_in = last_idx ? dfe_pkg::ST_E_RD : dfe_pkg::ST_F_PRED;
            end else if (preds_ff[sub_ff[4:0]]) begin
               state_in = dfe_pkg::ST_F_WALK;
            end
         end
         dfe_pkg::ST_F_WALK: begin
            state_in = walk_stop ? dfe_pkg::ST_F_SCAN : dfe_pkg::ST_F_MARK;
         end
         dfe_pkg::ST_F_MARK: state_in = dfe_pkg::ST_F_WALK;
         dfe_pkg::ST_E_RD:   state_in = dfe_pkg::ST_E_OUT;
         dfe_pkg::ST_E_OUT: begin
            state_in = last_idx ? dfe_pkg::ST_IDLE : dfe_pkg::ST_E_RD;
         end
         default: state_in = dfe_pkg::ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      n_in       = n_ff;
      all_in     = all_ff;
      idx_in     = idx_ff;
      sub_in     = sub_ff;
      runner_in  = runner_ff;
      steps_in   = steps_ff;
      ib_in      = ib_ff;
      preds_in   = preds_ff;
      acc_in     = acc_ff;
      old_in     = old_ff;
      strict_in  = strict_ff;
      changed_in = changed_ff;
      pred_we    = 1'b0;
      pred_wa    = req_block_index;
      pred_wd    = req_pred_mask;
      dom_we     = 1'b0;
      dom_wa     = idx_ff[4:0];
      dom_wd     = nd;
      idom_we    = 1'b0;
      idom_wa    = idx_ff[4:0];
      idom_wd    = dfe_pkg::NO_IDOM;
      front_we   = 1'b0;
      front_wa   = idx_ff[4:0];
      front_wd   = 32'd0;
      pred_ra    = idx_ff[4:0];
      dom_ra     = idx_ff[4:0];
      idom_ra    = idx_ff[4:0];
      front_ra   = idx_ff[4:0];
      case (state_ff)
         dfe_pkg::ST_IDLE: begin
            if (start) begin
               if (req_operation == dfe_pkg::OP_LOAD) begin
                  pred_we = (32'(req_block_index) < MAX_BLOCKS);
               end else begin
                  n_in   = eff_n;
                  all_in = eff_all;
                  idx_in = 6'd0;
               end
            end
         end
         dfe_pkg::ST_INIT: begin
            dom_we   = 1'b1;
            dom_wd   = (idx_ff == 6'd0) ? 32'd1 : all_ff;
            idom_we  = 1'b1;
            front_we = 1'b1;
            if (last_idx) begin
               idx_in     = (n_ff == 6'd1) ? 6'd0 : 6'd1;
               changed_in = 1'b0;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
         dfe_pkg::ST_D_LOAD: begin
            preds_in = pf;
            acc_in   = all_ff;
            old_in   = dom_rd;
            sub_in   = 6'd0;
         end
         dfe_pkg::ST_D_SCAN: begin
            if (!sub_end) begin
               if (preds_ff[sub_ff[4:0]]) begin
                  dom_ra = sub_ff[4:0];
               end else begin
                  sub_in = sub_ff + 6'd1;
               end
            end
         end
         dfe_pkg::ST_D_AND: begin
            acc_in = acc_ff & dom_rd;
            sub_in = sub_ff + 6'd1;
         end
         dfe_pkg::ST_D_WRITE: begin
            dom_we = 1'b1;
            if (last_idx) begin
               idx_in     = 6'd1;
               changed_in = 1'b0;
            end else begin
               idx_in     = idx_ff + 6'd1;
               changed_in = changed_ff | dom_diff;
            end
         end
         dfe_pkg::ST_I_LOAD: begin
            strict_in = dom_rd & ~imask;
            sub_in    = 6'd0;
         end
         dfe_pkg::ST_I_SCAN: begin
            if (sub_end) begin
               idx_in = last_idx ? 6'd1 : idx_ff + 6'd1;
            end else if (strict_ff[sub_ff[4:0]]) begin
               dom_ra = sub_ff[4:0];
            end else begin
               sub_in = sub_ff + 6'd1;
            end
         end
         dfe_pkg::ST_I_TEST: begin
            if (idom_hit) begin
               idom_we = 1'b1;
               idom_wd = sub_ff;
               idx_in  = last_idx ? 6'd1 : idx_ff + 6'd1;
            end else begin
               sub_in = sub_ff + 6'd1;
            end
         end
         dfe_pkg::ST_F_LOAD: begin
            preds_in = pf;
            ib_in    = idom_rd;
            sub_in   = 6'd0;
            if (!join_blk) begin
               idx_in = last_idx ? 6'd0 : idx_ff + 6'd1;
            end
         end
         dfe_pkg::ST_F_SCAN: begin
            if (sub_end) begin
               idx_in = last_idx ? 6'd0 : idx_ff + 6'd1;
            end else if (preds_ff[sub_ff[4:0]]) begin
               runner_in = sub_ff;
               steps_in  = 6'd0;
            end else begin
               sub_in = sub_ff + 6'd1;
            end
         end
         dfe_pkg::ST_F_WALK: begin
            if (walk_stop) begin
               sub_in = sub_ff + 6'd1;
            end else begin
               front_ra = runner_ff[4:0];
               idom_ra  = runner_ff[4:0];
            end
         end
         dfe_pkg::ST_F_MARK: begin
            front_we  = 1'b1;
            front_wa  = runner_ff[4:0];
            front_wd  = front_rd | imask;
            runner_in = idom_rd;
            steps_in  = steps_ff + 6'd1;
         end
         dfe_pkg::ST_E_OUT: begin
            idx_in = idx_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dfe_pkg::ST_IDLE;
         block_count_ff <= 6'd1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == dfe_pkg::ST_E_OUT);
         if (csr_write_enable) begin
            block_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      all_ff     <= all_in;
      idx_ff     <= idx_in;
      sub_ff     <= sub_in;
      runner_ff  <= runner_in;
      steps_ff   <= steps_in;
      ib_ff      <= ib_in;
      preds_ff   <= preds_in;
      acc_ff     <= acc_in;
      old_ff     <= old_in;
      strict_ff  <= strict_in;
      changed_ff <= changed_in;
      if (state_ff == dfe_pkg::ST_E_OUT) begin
         rsp_out_block_ff    <= idx_ff[4:0];
         rsp_has_idom_ff     <= has_idom;
         rsp_idom_block_ff   <= has_idom ? idom_rd[4:0] : 5'd0;
         rsp_dom_set_ff      <= dom_rd;
         rsp_frontier_set_ff <= front_rd;
         rsp_last_ff         <= last_idx;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_block    = rsp_out_block_ff;
   assign rsp_has_idom     = rsp_has_idom_ff;
   assign rsp_idom_block   = rsp_idom_block_ff;
   assign rsp_dom_set      = rsp_dom_set_ff;
   assign rsp_frontier_set = rsp_frontier_set_ff;
   assign rsp_last         = rsp_last_ff;

   `DFE_ASSERT_NEXT(a_compute_busy, clock, reset,
      start && !busy && req_operation == dfe_pkg::OP_COMPUTE, busy, "compute beat did not raise busy")
   `DFE_ASSERT_NEXT(a_last_ends, clock, reset,
      rsp_valid && rsp_last, !rsp_valid, "result beat after last")
   `DFE_ASSERT_NOW(a_self_dom, clock, reset,
      rsp_valid, rsp_dom_set[rsp_out_block], "block missing from own dominator set")
   `DFE_ASSERT_NOW(a_idom_dom, clock, reset,
      rsp_valid && rsp_has_idom, rsp_dom_set[rsp_idom_block], "idom not a dominator")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the dominator frontier engine. Predecessor rows and compute
// beats are sent through the start/busy port. A local dominator, idom and
// frontier solver predicts every result beat, and each result is checked
// field by field in arrival order. The block count is changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   typedef struct packed {
      logic [4:0]  blk;
      logic        has_idom;
      logic [4:0]  idom_blk;
      logic [31:0] dom;
      logic [31:0] frontier;
      logic        last;
   } block_info_type;

   localparam int WATCHDOG_LIMIT = 1000000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [4:0]  req_block_index;
   logic [31:0] req_pred_mask;
   logic        rsp_valid;
   logic [4:0]  rsp_out_block;
   logic        rsp_has_idom;
   logic [4:0]  rsp_idom_block;
   logic [31:0] rsp_dom_set;
   logic [31:0] rsp_frontier_set;
   logic        rsp_last;
   logic        csr_write_enable;
   logic [5:0]  csr_write_data;

   dominator_frontier_engine_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_block_index(req_block_index),
      .req_pred_mask(req_pred_mask), .rsp_valid(rsp_valid),
      .rsp_out_block(rsp_out_block), .rsp_has_idom(rsp_has_idom),
      .rsp_idom_block(rsp_idom_block), .rsp_dom_set(rsp_dom_set),
      .rsp_frontier_set(rsp_frontier_set), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   logic [31:0]    model_preds [32];
   logic [5:0]     model_count;
   block_info_type expected_blocks [$];
   int             error_count = 0;
   int             beats_sent = 0;
   int             computes_sent = 0;
   int             results_seen = 0;
   int             idle_cycles = 0;
   bit             gaps_on = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void solve_graph();
      int unsigned n;
      logic [32:0] wide;
      logic [31:0] all, preds, nd, strict;
      logic [31:0] dom [32];
      logic [31:0] front [32];
      logic [5:0]  idom [32];
      int unsigned runner, steps;
      bit changed;
      block_info_type r;
      n = (model_count == 0) ? 1 : ((model_count > 32) ? 32 : model_count);
      wide = (33'd1 << n) - 33'd1;
      all = wide[31:0];
      for (int i = 0; i < 32; i++) begin
         dom[i] = (i == 0) ? 32'd1 : all;
         idom[i] = dfe_pkg::NO_IDOM;
         front[i] = '0;
      end
      changed = 1;
      while (changed) begin
         changed = 0;
         for (int i = 1; i < n; i++) begin
            preds = model_preds[i] & all;
            nd = all;
            if (preds == 0) nd = '0;
            else for (int j = 0; j < n; j++) if (preds[j]) nd &= dom[j];
            nd[i] = 1'b1;
            if (nd != dom[i]) begin
               dom[i] = nd;
               changed = 1;
            end
         end
      end
      for (int i = 1; i < n; i++) begin
         strict = dom[i];
         strict[i] = 1'b0;
         for (int c = 0; c < n; c++) begin
            if (strict[c] && ((strict & ~(32'd1 << c) & ~dom[c]) == 0)) begin
               idom[i] = c[5:0];
               break;
            end
         end
      end
      for (int b = 1; b < n; b++) begin
         preds = model_preds[b] & all;
         if ($countones(preds) < 2) continue;
         for (int p = 0; p < n; p++) begin
            if (!preds[p]) continue;
            runner = p;
            steps = 0;
            while (runner != idom[b] && runner < n && steps < n) begin
               front[runner][b] = 1'b1;
               runner = idom[runner];
               steps++;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         r.blk = i[4:0];
         r.has_idom = (idom[i] < n);
         r.idom_blk = r.has_idom ? idom[i][4:0] : 5'd0;
         r.dom = dom[i];
         r.frontier = front[i];
         r.last = (i == n - 1);
         expected_blocks = {expected_blocks, r};
      end
   endfunction

   // assumes the caller sits at a clock edge; leaves start high on return
   task automatic send_beat(input logic op, input logic [4:0] idx, input logic [31:0] mask);
      int gap;
      gap = (gaps_on && $urandom_range(3, 0) == 0) ? $urandom_range(19, 1) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_block_index <= idx;
      req_pred_mask <= mask;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
      if (op == dfe_pkg::OP_LOAD) model_preds[idx] = mask;
      else begin
         computes_sent++;
         solve_graph();
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_blocks.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_count(input logic [5:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_count = value;
   endtask

   // reachable graph: every block but 0 gets a lower predecessor, plus extra edges
   task automatic load_graph(input int unsigned n);
      logic [31:0] m;
      for (int i = 0; i < n; i++) begin
         m = $urandom();
         if ($urandom_range(1, 0)) m &= $urandom();
         if (i > 0) m[$urandom_range(i - 1, 0)] = 1'b1;
         send_beat(dfe_pkg::OP_LOAD, i[4:0], m);
      end
   endtask

   task automatic test_directed();
      for (int i = 0; i < 32; i++)
         send_beat(dfe_pkg::OP_LOAD, i[4:0], (i == 31) ? '1 : '0);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
      write_count(6'd5);
      // diamond 0->1,2 -> 3, back edge 3->1, block 4 unreachable
      send_beat(dfe_pkg::OP_LOAD, 5'd1, 32'h0000_0009);
      send_beat(dfe_pkg::OP_LOAD, 5'd2, 32'h0000_0001);
      send_beat(dfe_pkg::OP_LOAD, 5'd3, 32'hFFFF_FFE6);
      send_beat(dfe_pkg::OP_LOAD, 5'd4, 32'h0000_0000);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd31, '1);
      // unreachable self-looping block 4 feeding a join at block 2
      send_beat(dfe_pkg::OP_LOAD, 5'd4, 32'h0000_0010);
      send_beat(dfe_pkg::OP_LOAD, 5'd2, 32'h0000_0011);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
      write_count(6'd0);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
   endtask

   task automatic test_count_extremes();
      write_count(6'd63);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
      write_count(6'd32);
      load_graph(32);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
      write_count(6'd33);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
      write_count(6'd1);
      send_beat(dfe_pkg::OP_LOAD, 5'd0, '1);
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
   endtask

   task automatic test_random(input int target);
      int unsigned n;
      while (beats_sent < target) begin
         n = ($urandom_range(9, 0) == 0) ? $urandom_range(32, 1) : $urandom_range(8, 2);
         write_count(n[5:0]);
         if ($urandom_range(4, 0) == 0) begin
            for (int k = 0; k < n; k++) send_beat(dfe_pkg::OP_LOAD, k[4:0], $urandom());
         end else load_graph(n);
         if ($urandom_range(2, 0) == 0)
            send_beat(dfe_pkg::OP_LOAD, 5'($urandom_range(31, 0)), $urandom());
         send_beat(dfe_pkg::OP_COMPUTE, 5'($urandom()), $urandom());
         if ($urandom_range(4, 0) == 0)
            send_beat(dfe_pkg::OP_COMPUTE, 5'($urandom()), $urandom());
      end
   endtask

   task automatic test_hold_off();
      drain();
      send_beat(dfe_pkg::OP_COMPUTE, 5'd0, '0);
   endtask

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      block_info_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_blocks.size() == 0) begin
            $error("unexpected result beat for block %0d", rsp_out_block);
            error_count++;
         end else begin
            e = expected_blocks.pop_front();
            check_field("out_block", 32'(e.blk), 32'(rsp_out_block));
            check_field("has_idom", 32'(e.has_idom), 32'(rsp_has_idom));
            check_field("idom_block", 32'(e.idom_blk), 32'(rsp_idom_block));
            check_field("dom_set", e.dom, rsp_dom_set);
            check_field("frontier_set", e.frontier, rsp_frontier_set);
            check_field("last", 32'(e.last), 32'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", expected_blocks.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = dfe_pkg::OP_LOAD;
      req_block_index = '0;
      req_pred_mask = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      model_count = 6'd1;
      for (int i = 0; i < 32; i++) model_preds[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_count_extremes();
      test_random(200);
      test_hold_off();
      test_random(255);
      gaps_on = 0;
      test_random(290);
      drain();
      repeat (20) @(posedge clock);
      if (expected_blocks.size() != 0) begin
         $error("%0d expected result beats never arrived", expected_blocks.size());
         error_count++;
      end
      $display("sent %0d beats (%0d compute), checked %0d result beats",
               beats_sent, computes_sent, results_seen);
      $display("random graphs of 1 to 32 blocks, counts 0, 33 and 63 clamped, with and without gaps");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
